@@ sv/i2c_master_register_access_top_assert.svh @@
// ----------------------------------------------------------------------------
// I2C master register access assertion macros
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_TOP_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define I2C_MRA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2c master register access check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define I2C_MRA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c master register access check failed");

`endif

@@ sv/i2c_mra_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types, step codes and line level decoding.
// ----------------------------------------------------------------------------
package i2c_mra_pkg;

	localparam logic [15:0] TPP_RESET = 16'd256;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'd0,
		ST_S1    = 5'd1,
		ST_S2    = 5'd2,
		ST_AW_L  = 5'd3,
		ST_AW_H  = 5'd4,
		ST_AW_AL = 5'd5,
		ST_AW_AH = 5'd6,
		ST_RG_L  = 5'd7,
		ST_RG_H  = 5'd8,
		ST_RG_AL = 5'd9,
		ST_RG_AH = 5'd10,
		ST_DT_L  = 5'd11,
		ST_DT_H  = 5'd12,
		ST_DT_AL = 5'd13,
		ST_DT_AH = 5'd14,
		ST_RS1   = 5'd15,
		ST_RS2   = 5'd16,
		ST_RS3   = 5'd17,
		ST_AR_L  = 5'd18,
		ST_AR_H  = 5'd19,
		ST_AR_AL = 5'd20,
		ST_AR_AH = 5'd21,
		ST_RX_L  = 5'd22,
		ST_RX_H  = 5'd23,
		ST_MN_L  = 5'd24,
		ST_MN_H  = 5'd25,
		ST_SP1   = 5'd26,
		ST_SP2   = 5'd27,
		ST_SP3   = 5'd28
	} step_t;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] device_address;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_result;
		logic       nack_seen;
	} res_t;

	function automatic logic scl_of(step_t s);
		logic r;
		case (s)
			ST_AW_L, ST_AW_AL, ST_RG_L, ST_RG_AL, ST_DT_L, ST_DT_AL,
			ST_RS1, ST_AR_L, ST_AR_AL, ST_RX_L, ST_MN_L, ST_SP1: r = 1'b0;
			default: r = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic sda_of(step_t s, logic msb);
		logic r;
		case (s)
			ST_AW_L, ST_AW_H, ST_RG_L, ST_RG_H, ST_DT_L, ST_DT_H,
			ST_AR_L, ST_AR_H: r = msb;
			ST_S2, ST_RS3, ST_SP1, ST_SP2: r = 1'b0;
			default: r = 1'b1;
		endcase
		return r;
	endfunction

endpackage

@@ sv/i2c_mra_if.sv @@
// ----------------------------------------------------------------------------
// I2C master register access channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface i2c_mra_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [6:0] device_address;
	logic [7:0] reg_address;
	logic [7:0] write_data;
	logic       sda_in;

	modport source (output valid, op, device_address, reg_address, write_data, sda_in,
		input ready);
	modport sink (input valid, op, device_address, reg_address, write_data, sda_in,
		output ready);
endinterface

interface i2c_mra_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_result;
	logic       nack_seen;

	modport source (output valid, scl_level, sda_drive, busy_res, done_res, read_result,
		nack_seen, input ready);
	modport sink (input valid, scl_level, sda_drive, busy_res, done_res, read_result,
		nack_seen, output ready);
endinterface

@@ sv/i2c_mra_seq.sv @@
// ----------------------------------------------------------------------------
// I2C master register access sequencer
// Transaction state and phase timing, advanced once per accepted beat.
// ----------------------------------------------------------------------------
module i2c_mra_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  i2c_mra_pkg::item_t  item,
	input  logic [15:0]         ticks_per_phase,
	output i2c_mra_pkg::res_t   res
);
	import i2c_mra_pkg::*;

	step_t       step_q, step_d;
	logic [15:0] pc_q, pc_d;
	logic [3:0]  bc_q, bc_d;
	logic [7:0]  shift_q, shift_d;
	logic [6:0]  dev_q, dev_d;
	logic [7:0]  reg_q, reg_d;
	logic [7:0]  data_q, data_d;
	logic        rd_q, rd_d;
	logic [7:0]  rx_q, rx_d;
	logic        nack_q, nack_d;
	logic        done;
	logic [15:0] pc_inc;
	logic [15:0] limit;
	logic        last;
	logic [7:0]  rx_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			pc_q    <= '0;
			bc_q    <= '0;
			shift_q <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
			data_q  <= '0;
			rd_q    <= 1'b0;
			rx_q    <= '0;
			nack_q  <= 1'b0;
		end else if (accept) begin
			step_q  <= step_d;
			pc_q    <= pc_d;
			bc_q    <= bc_d;
			shift_q <= shift_d;
			dev_q   <= dev_d;
			reg_q   <= reg_d;
			data_q  <= data_d;
			rd_q    <= rd_d;
			rx_q    <= rx_d;
			nack_q  <= nack_d;
		end
	end

	always_comb begin
		step_d   = step_q;
		pc_d     = pc_q;
		bc_d     = bc_q;
		shift_d  = shift_q;
		dev_d    = dev_q;
		reg_d    = reg_q;
		data_d   = data_q;
		rd_d     = rd_q;
		rx_d     = rx_q;
		nack_d   = nack_q;
		done     = 1'b0;
		pc_inc   = pc_q + 16'd1;
		limit    = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
		last     = (bc_q >= 4'd7);
		rx_shift = {shift_q[6:0], item.sda_in};
		case (op_t'(item.op))
			OP_TICK: begin
				if (step_q != ST_IDLE) begin
					pc_d = pc_inc;
					if (pc_inc >= limit) begin
						pc_d = '0;
						case (step_q)
							ST_S1: step_d = ST_S2;
							ST_S2: begin
								step_d  = ST_AW_L;
								shift_d = {dev_q, 1'b0};
								bc_d    = '0;
							end
							ST_AW_L:  step_d = ST_AW_H;
							ST_RG_L:  step_d = ST_RG_H;
							ST_DT_L:  step_d = ST_DT_H;
							ST_AR_L:  step_d = ST_AR_H;
							ST_AW_H, ST_RG_H, ST_DT_H, ST_AR_H: begin
								shift_d = {shift_q[6:0], 1'b0};
								bc_d    = last ? 4'd0 : bc_q + 4'd1;
								case (step_q)
									ST_AW_H: step_d = last ? ST_AW_AL : ST_AW_L;
									ST_RG_H: step_d = last ? ST_RG_AL : ST_RG_L;
									ST_DT_H: step_d = last ? ST_DT_AL : ST_DT_L;
									default: step_d = last ? ST_AR_AL : ST_AR_L;
								endcase
							end
							ST_AW_AL: step_d = ST_AW_AH;
							ST_RG_AL: step_d = ST_RG_AH;
							ST_DT_AL: step_d = ST_DT_AH;
							ST_AR_AL: step_d = ST_AR_AH;
							ST_AW_AH: begin
								nack_d  = nack_q | item.sda_in;
								step_d  = ST_RG_L;
								shift_d = reg_q;
								bc_d    = '0;
							end
							ST_RG_AH: begin
								nack_d = nack_q | item.sda_in;
								if (rd_q) begin
									step_d = ST_RS1;
								end else begin
									step_d  = ST_DT_L;
									shift_d = data_q;
									bc_d    = '0;
								end
							end
							ST_DT_AH: begin
								nack_d = nack_q | item.sda_in;
								step_d = ST_SP1;
							end
							ST_RS1: step_d = ST_RS2;
							ST_RS2: step_d = ST_RS3;
							ST_RS3: begin
								step_d  = ST_AR_L;
								shift_d = {dev_q, 1'b1};
								bc_d    = '0;
							end
							ST_AR_AH: begin
								nack_d  = nack_q | item.sda_in;
								step_d  = ST_RX_L;
								shift_d = '0;
								bc_d    = '0;
							end
							ST_RX_L: step_d = ST_RX_H;
							ST_RX_H: begin
								shift_d = rx_shift;
								if (last) begin
									rx_d   = rx_shift;
									bc_d   = '0;
									step_d = ST_MN_L;
								end else begin
									bc_d   = bc_q + 4'd1;
									step_d = ST_RX_L;
								end
							end
							ST_MN_L: step_d = ST_MN_H;
							ST_MN_H: step_d = ST_SP1;
							ST_SP1:  step_d = ST_SP2;
							ST_SP2:  step_d = ST_SP3;
							ST_SP3: begin
								step_d = ST_IDLE;
								done   = 1'b1;
							end
							default: step_d = ST_IDLE;
						endcase
					end
				end
			end
			OP_WRITE, OP_READ: begin
				if (step_q == ST_IDLE) begin
					dev_d  = item.device_address;
					reg_d  = item.reg_address;
					data_d = item.write_data;
					rd_d   = (op_t'(item.op) == OP_READ);
					nack_d = 1'b0;
					pc_d   = '0;
					bc_d   = '0;
					step_d = ST_S1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.scl_level   = scl_of(step_d);
		res.sda_drive   = sda_of(step_d, shift_d[7]);
		res.busy_res    = (step_d != ST_IDLE);
		res.done_res    = done;
		res.read_result = rx_d;
		res.nack_seen   = nack_d;
	end

endmodule

@@ sv/i2c_master_register_access_top.sv @@
// ----------------------------------------------------------------------------
// I2C master register access top level
// Single register write or read master driven by tick and command beats.
// ----------------------------------------------------------------------------
// The in_ch channel carries one beat per tick or command: op 0 is a time
// tick, op 1 starts a register write and op 2 starts a register read. A
// command beat while a transaction runs is ignored. Every accepted beat
// yields exactly one result beat on out_ch with the SCL and SDA levels, the
// busy and done flags, the last received byte and the sticky nack flag.
// The SDA level sampled in sda_in is used at the end of acknowledge and
// receive phases. Each line phase lasts ticks_per_phase ticks, written through
// cfg_wr_en and cfg_wr_data by the user only while idle, unchecked by the
// block; zero acts as one. A registered result appears in the cycle after its
// beat is accepted; one beat can be accepted in every cycle, limited only by
// the single output register. When out_ch stalls, in_ch stays ready only if
// the held result is taken in the same cycle. Reset clears the sequencer to
// idle with both lines released and sets the phase length to 256 ticks.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data,
	i2c_mra_in_if.sink    in_ch,
	i2c_mra_out_if.source out_ch
);
	import i2c_mra_pkg::*;

	`include "i2c_master_register_access_top_assert.svh"

	logic [15:0] tpp_q;
	item_t       item;
	res_t        res;
	res_t        out_q;
	logic        out_valid_q;
	logic        accept;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign item.op             = in_ch.op;
	assign item.device_address = in_ch.device_address;
	assign item.reg_address    = in_ch.reg_address;
	assign item.write_data     = in_ch.write_data;
	assign item.sda_in         = in_ch.sda_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpp_q <= TPP_RESET;
		end else if (cfg_wr_en) begin
			tpp_q <= cfg_wr_data;
		end
	end

	i2c_mra_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.item            (item),
		.ticks_per_phase (tpp_q),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.scl_level   = out_q.scl_level;
	assign out_ch.sda_drive   = out_q.sda_drive;
	assign out_ch.busy_res    = out_q.busy_res;
	assign out_ch.done_res    = out_q.done_res;
	assign out_ch.read_result = out_q.read_result;
	assign out_ch.nack_seen   = out_q.nack_seen;

	`I2C_MRA_ASSERT_NOW(a_done_not_busy, out_valid_q && out_q.done_res, !out_q.busy_res)
	`I2C_MRA_ASSERT_NOW(a_idle_released, out_valid_q && !out_q.busy_res,
		out_q.scl_level && out_q.sda_drive)
	`I2C_MRA_ASSERT_NOW(a_stall_blocks, out_valid_q && !out_ch.ready, !in_ch.ready)
	`I2C_MRA_ASSERT_NEXT(a_accept_shows, accept, out_valid_q)

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// I2C master register access testbench
// Sends tick and command beats to the master and tracks the SCL and SDA
// sequence of every single register write and read in a local model. Each
// result beat is compared field by field with the modeled line levels, the
// busy and done flags, the received byte and the sticky nack flag. Covers
// idle beats, the reset, zero, minimum and maximum phase lengths, a long
// output stall, and random transactions under several idle patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2c_mra_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int BEATS_PER_PHASE = 30;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	i2c_mra_in_if  in_ch ();
	i2c_mra_out_if out_ch ();

	i2c_master_register_access_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [15:0] phase_len;
	step_t       bus_step;
	logic [15:0] phase_ticks;
	logic [3:0]  bits_done;
	logic [7:0]  shifter;
	logic [6:0]  held_dev;
	logic [7:0]  held_reg;
	logic [7:0]  held_wdata;
	logic        read_cmd;
	logic [7:0]  rx_byte;
	logic        nack_flag;
	logic        scl_q;
	logic        sda_q;

	res_t expected_levels[$];

	int mismatch_count;
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_off_cycles;
	int idle_cycles;
	int sda_high_pct;
	int useful_beats;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void reset_bus_model();
		phase_len = TPP_RESET;
		bus_step = ST_IDLE;
		phase_ticks = '0;
		bits_done = '0;
		shifter = '0;
		held_dev = '0;
		held_reg = '0;
		held_wdata = '0;
		read_cmd = 1'b0;
		rx_byte = '0;
		nack_flag = 1'b0;
		scl_q = 1'b1;
		sda_q = 1'b1;
	endfunction

	function automatic void drive_line_levels();
		case (bus_step)
			ST_AW_L, ST_AW_AL, ST_RG_L, ST_RG_AL, ST_DT_L, ST_DT_AL, ST_RS1,
			ST_AR_L, ST_AR_AL, ST_RX_L, ST_MN_L, ST_SP1: scl_q = 1'b0;
			default: scl_q = 1'b1;
		endcase
		case (bus_step)
			ST_AW_L, ST_AW_H, ST_RG_L, ST_RG_H, ST_DT_L, ST_DT_H, ST_AR_L, ST_AR_H: begin
				sda_q = shifter[7];
			end
			ST_S2, ST_RS3, ST_SP1, ST_SP2: sda_q = 1'b0;
			default: sda_q = 1'b1;
		endcase
	endfunction

	function automatic logic finish_line_phase(input logic sda);
		logic done;
		done = 1'b0;
		case (bus_step)
			ST_S1: bus_step = ST_S2;
			ST_S2: begin
				shifter = {held_dev, 1'b0};
				bits_done = '0;
				bus_step = ST_AW_L;
			end
			ST_AW_L, ST_RG_L, ST_DT_L, ST_AR_L, ST_AW_AL, ST_RG_AL, ST_DT_AL, ST_AR_AL,
			ST_RS1, ST_RS2, ST_SP1, ST_SP2: begin
				bus_step = step_t'(bus_step + 5'd1);
			end
			ST_AW_H, ST_RG_H, ST_DT_H, ST_AR_H: begin
				shifter = shifter << 1;
				bits_done = bits_done + 4'd1;
				if (bits_done >= 4'd8) begin
					bits_done = '0;
					bus_step = step_t'(bus_step + 5'd1);
				end else begin
					bus_step = step_t'(bus_step - 5'd1);
				end
			end
			ST_AW_AH: begin
				nack_flag = nack_flag | sda;
				shifter = held_reg;
				bits_done = '0;
				bus_step = ST_RG_L;
			end
			ST_RG_AH: begin
				nack_flag = nack_flag | sda;
				if (read_cmd) begin
					bus_step = ST_RS1;
				end else begin
					shifter = held_wdata;
					bits_done = '0;
					bus_step = ST_DT_L;
				end
			end
			ST_DT_AH: begin
				nack_flag = nack_flag | sda;
				bus_step = ST_SP1;
			end
			ST_RS3: begin
				shifter = {held_dev, 1'b1};
				bits_done = '0;
				bus_step = ST_AR_L;
			end
			ST_AR_AH: begin
				nack_flag = nack_flag | sda;
				shifter = '0;
				bits_done = '0;
				bus_step = ST_RX_L;
			end
			ST_RX_L: bus_step = ST_RX_H;
			ST_RX_H: begin
				shifter = {shifter[6:0], sda};
				bits_done = bits_done + 4'd1;
				if (bits_done >= 4'd8) begin
					rx_byte = shifter;
					bits_done = '0;
					bus_step = ST_MN_L;
				end else begin
					bus_step = ST_RX_L;
				end
			end
			ST_MN_L: bus_step = ST_MN_H;
			ST_MN_H: bus_step = ST_SP1;
			ST_SP3: begin
				bus_step = ST_IDLE;
				done = 1'b1;
			end
			default: bus_step = ST_IDLE;
		endcase
		drive_line_levels();
		return done;
	endfunction

	function automatic res_t advance_bus_sequencer(input item_t it);
		res_t        r;
		logic        done;
		logic [15:0] limit;
		done = 1'b0;
		if (it.op == OP_TICK) begin
			if (bus_step != ST_IDLE) begin
				limit = (phase_len == 16'd0) ? 16'd1 : phase_len;
				phase_ticks = phase_ticks + 16'd1;
				if (phase_ticks >= limit) begin
					phase_ticks = '0;
					done = finish_line_phase(it.sda_in);
				end
			end
		end else if ((it.op == OP_WRITE || it.op == OP_READ) && bus_step == ST_IDLE) begin
			held_dev = it.device_address;
			held_reg = it.reg_address;
			held_wdata = it.write_data;
			read_cmd = (it.op == OP_READ);
			nack_flag = 1'b0;
			phase_ticks = '0;
			bits_done = '0;
			bus_step = ST_S1;
			drive_line_levels();
		end
		r.scl_level = scl_q;
		r.sda_drive = sda_q;
		r.busy_res = (bus_step != ST_IDLE);
		r.done_res = done;
		r.read_result = rx_byte;
		r.nack_seen = nack_flag;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_levels.size() == 0) begin
				report_mismatch("result beat with none expected", 8'h00, 8'h00);
			end else begin
				want = expected_levels.pop_front();
				if (out_ch.scl_level !== want.scl_level)
					report_mismatch("scl_level", 8'(out_ch.scl_level), 8'(want.scl_level));
				if (out_ch.sda_drive !== want.sda_drive)
					report_mismatch("sda_drive", 8'(out_ch.sda_drive), 8'(want.sda_drive));
				if (out_ch.busy_res !== want.busy_res)
					report_mismatch("busy_res", 8'(out_ch.busy_res), 8'(want.busy_res));
				if (out_ch.done_res !== want.done_res)
					report_mismatch("done_res", 8'(out_ch.done_res), 8'(want.done_res));
				if (out_ch.read_result !== want.read_result)
					report_mismatch("read_result", out_ch.read_result, want.read_result);
				if (out_ch.nack_seen !== want.nack_seen)
					report_mismatch("nack_seen", 8'(out_ch.nack_seen), 8'(want.nack_seen));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ch.ready <= 1'b0;
			hold_off_cycles = hold_off_cycles - 1;
		end else begin
			out_ch.ready <= ($urandom_range(1, 100) > receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic logic pick_sda();
		return ($urandom_range(1, 100) <= sda_high_pct);
	endfunction

	function automatic item_t tick_item(input logic sda);
		item_t it;
		it.op = OP_TICK;
		it.device_address = 7'($urandom);
		it.reg_address = 8'($urandom);
		it.write_data = 8'($urandom);
		it.sda_in = sda;
		return it;
	endfunction

	function automatic item_t command_item(input logic [1:0] op, input logic [6:0] dev,
		input logic [7:0] rg, input logic [7:0] wd);
		item_t it;
		it.op = op;
		it.device_address = dev;
		it.reg_address = rg;
		it.write_data = wd;
		it.sda_in = 1'($urandom);
		return it;
	endfunction

	task automatic send_beat(input item_t it);
		while (sender_idle_pct > 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= it.op;
		in_ch.device_address <= it.device_address;
		in_ch.reg_address <= it.reg_address;
		in_ch.write_data <= it.write_data;
		in_ch.sda_in <= it.sda_in;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		expected_levels.push_back(advance_bus_sequencer(it));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_phase_length(input logic [15:0] len);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		phase_len = len;
		@(negedge clk);
	endtask

	task automatic run_transaction(input logic [1:0] op, input logic [6:0] dev,
		input logic [7:0] rg, input logic [7:0] wd, input int noise_pct);
		send_beat(command_item(op, dev, rg, wd));
		useful_beats++;
		while (bus_step != ST_IDLE) begin
			if ($urandom_range(1, 100) <= noise_pct) begin
				send_beat(command_item(2'($urandom_range(1, 3)), 7'($urandom),
					8'($urandom), 8'($urandom)));
			end else begin
				send_beat(tick_item(pick_sda()));
				useful_beats++;
			end
		end
	endtask

	task automatic test_idle_beats();
		send_beat(tick_item(1'b0));
		send_beat(tick_item(1'b1));
		send_beat(command_item(OP_UNUSED, 7'h7F, 8'hFF, 8'hFF));
		send_beat(command_item(OP_UNUSED, 7'h00, 8'h00, 8'h00));
	endtask

	task automatic test_reset_phase_length();
		sda_high_pct = 0;
		send_beat(command_item(OP_WRITE, 7'h7F, 8'hFF, 8'h00));
		repeat (int'(TPP_RESET) + 1) send_beat(tick_item(pick_sda()));
		write_phase_length(16'd1);
		while (bus_step != ST_IDLE) send_beat(tick_item(pick_sda()));
	endtask

	task automatic test_zero_phase_length();
		write_phase_length(16'd0);
		sda_high_pct = 100;
		run_transaction(OP_READ, 7'h00, 8'h00, 8'hFF, 5);
	endtask

	task automatic test_min_phase_length();
		write_phase_length(16'd1);
		sda_high_pct = 50;
		run_transaction(OP_WRITE, 7'h2A, 8'h55, 8'hA5, 5);
	endtask

	task automatic test_max_phase_length();
		write_phase_length(16'hFFFF);
		send_beat(tick_item(1'b1));
		send_beat(command_item(OP_UNUSED, 7'h55, 8'hAA, 8'h55));
		send_beat(tick_item(1'b0));
	endtask

	task automatic test_output_hold_off();
		write_phase_length(16'd1);
		sda_high_pct = 30;
		hold_off_cycles = 60;
		run_transaction(OP_READ, 7'($urandom), 8'($urandom), 8'($urandom), 3);
	endtask

	task automatic test_random_traffic();
		int phase_start;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 66;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 66;
				end
				default: begin
					sender_idle_pct = 12;
					receiver_stall_pct = 12;
				end
			endcase
			write_phase_length(16'($urandom_range(0, 1)));
			phase_start = useful_beats;
			while (useful_beats - phase_start < BEATS_PER_PHASE) begin
				sda_high_pct = $urandom_range(0, 1) ? 50 : 10;
				if ($urandom_range(1, 10) == 1) begin
					if ($urandom_range(0, 1))
						send_beat(tick_item(pick_sda()));
					else
						send_beat(command_item(OP_UNUSED, 7'($urandom), 8'($urandom),
							8'($urandom)));
				end else begin
					run_transaction($urandom_range(0, 1) ? OP_READ : OP_WRITE,
						7'($urandom), 8'($urandom), 8'($urandom), 4);
				end
			end
		end
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_TICK;
		in_ch.device_address = '0;
		in_ch.reg_address = '0;
		in_ch.write_data = '0;
		in_ch.sda_in = 1'b0;
		out_ch.ready = 1'b0;
		mismatch_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_cycles = 0;
		idle_cycles = 0;
		sda_high_pct = 0;
		useful_beats = 0;
		reset_bus_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_beats();
		test_reset_phase_length();
		test_zero_phase_length();
		test_min_phase_length();
		test_max_phase_length();
		test_output_hold_off();
		test_random_traffic();

		drain_results();
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/i2c_mra_pkg.sv
sv/i2c_mra_if.sv
sv/i2c_mra_seq.sv
sv/i2c_master_register_access_top.sv
verif/tb.sv
